/* rtl/core/matrix3_inverse_defines.svh */
// Assertion macros used by the matrix inverse port checker
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// same-cycle implication, masked during reset
`define M3I_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define M3I_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state in the cycle after reset
`define M3I_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

/* rtl/core/m3i_pkg.sv */
// Types, widths and constants of the 3x3 matrix inverse pipeline
`default_nettype none
package m3i_pkg;

  localparam int unsigned ENT_W     = 32;
  localparam int unsigned N_ENT     = 9;
  localparam int unsigned TDATA_W   = ENT_W * N_ENT;
  localparam int unsigned THR_W     = 31;
  localparam int unsigned THR_RESET = 16;

  localparam int unsigned PROD_W    = 2 * ENT_W;
  localparam int unsigned COF_W     = PROD_W + 1;
  localparam int unsigned COF_LO_W  = ENT_W + 1;
  localparam int unsigned PL_W      = ENT_W + COF_LO_W + 1;
  localparam int unsigned PH_W      = ENT_W + COF_W - COF_LO_W;
  localparam int unsigned SL_W      = PL_W + 2;
  localparam int unsigned SH_W      = PH_W + 2;
  localparam int unsigned DET_W     = SH_W + COF_LO_W + 1;
  localparam int unsigned CABS_W    = COF_W - 1;
  localparam int unsigned NUM_SHIFT = ENT_W + 1;
  localparam int unsigned THR_SHIFT = ENT_W;
  localparam int unsigned NUM_W     = DET_W + 1;
  localparam int unsigned QW        = ENT_W;
  localparam int unsigned RW        = NUM_W + QW;

  // pipeline stage map
  localparam int unsigned DIV_S0 = 8;
  localparam int unsigned SING_S = 7;
  localparam int unsigned NS     = DIV_S0 + QW + 2;

  localparam logic [ENT_W-1:0] ENT_MAX = {1'b0, {(ENT_W-1){1'b1}}};
  localparam logic [ENT_W-1:0] ENT_MIN = {1'b1, {(ENT_W-1){1'b0}}};

  // cofactor k = a[A]*a[B] - a[C]*a[D]
  localparam int unsigned COF_A [0:8] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [0:8] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [0:8] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_D [0:8] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic signed [ENT_W-1:0]  entry_t;
  typedef entry_t                   mat_t [0:N_ENT-1];
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef cof_t                     cof_arr_t [0:N_ENT-1];
  typedef logic [NUM_W-1:0]         num_t;
  typedef num_t                     num_arr_t [0:N_ENT-1];
  typedef logic [QW-1:0]            quo_t;
  typedef quo_t                     quo_arr_t [0:N_ENT-1];

  typedef struct packed {
    logic [N_ENT-1:0] neg;
    logic             sing;
  } det_stat_t;

  typedef struct packed {
    logic [N_ENT-1:0] neg;
    logic [N_ENT-1:0] ovf;
  } div_stat_t;

endpackage
`default_nettype wire

/* rtl/core/m3i_cof.sv */
// Cofactor stages: eighteen products, then nine differences
`default_nettype none
module m3i_cof (
  input  logic              clk,
  input  logic [1:0]        en,
  input  m3i_pkg::mat_t     a,
  output m3i_pkg::cof_arr_t c
);

  logic signed [m3i_pkg::PROD_W-1:0] p_ab [0:m3i_pkg::N_ENT-1];
  logic signed [m3i_pkg::PROD_W-1:0] p_cd [0:m3i_pkg::N_ENT-1];

  for (genvar k = 0; k < m3i_pkg::N_ENT; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en[0]) begin
        p_ab[k] <= a[m3i_pkg::COF_A[k]] * a[m3i_pkg::COF_B[k]];
        p_cd[k] <= a[m3i_pkg::COF_C[k]] * a[m3i_pkg::COF_D[k]];
      end
      if (en[1]) begin
        c[k] <= m3i_pkg::COF_W'(p_ab[k]) - m3i_pkg::COF_W'(p_cd[k]);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/m3i_det.sv */
// Determinant, singular test and divider operands
`default_nettype none
module m3i_det (
  input  logic                      clk,
  input  logic [4:0]                en,
  input  m3i_pkg::mat_t             a,
  input  m3i_pkg::cof_arr_t         c,
  input  logic [m3i_pkg::THR_W-1:0] thr,
  output m3i_pkg::num_arr_t         num,
  output m3i_pkg::num_t             den,
  output m3i_pkg::det_stat_t        stat
);

  localparam int unsigned NE = m3i_pkg::N_ENT;

  logic signed [m3i_pkg::PL_W-1:0]  pl [0:2];
  logic signed [m3i_pkg::PH_W-1:0]  ph [0:2];
  logic signed [m3i_pkg::SL_W-1:0]  sl;
  logic signed [m3i_pkg::SH_W-1:0]  sh;
  logic signed [m3i_pkg::DET_W-1:0] det;
  logic [m3i_pkg::DET_W-1:0]        md;
  logic                             dz;
  logic [m3i_pkg::CABS_W-1:0]       cabs3 [0:NE-1];
  logic [m3i_pkg::CABS_W-1:0]       cabs4 [0:NE-1];
  logic [m3i_pkg::CABS_W-1:0]       cabs5 [0:NE-1];
  logic [m3i_pkg::CABS_W-1:0]       cabs6 [0:NE-1];
  logic [NE-1:0]                    cneg3, cneg4, cneg5, neg6;

  for (genvar j = 0; j < 3; j++) begin : g_part
    always_ff @(posedge clk) begin
      if (en[0]) begin
        pl[j] <= a[j] * $signed({1'b0, c[3*j][m3i_pkg::COF_LO_W-1:0]});
        ph[j] <= a[j] * $signed(c[3*j][m3i_pkg::COF_W-1:m3i_pkg::COF_LO_W]);
      end
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en[0]) begin
        cabs3[k] <= c[k][m3i_pkg::COF_W-1] ? m3i_pkg::CABS_W'(-c[k])
                                           : m3i_pkg::CABS_W'(c[k]);
        cneg3[k] <= c[k][m3i_pkg::COF_W-1];
      end
      if (en[1]) begin
        cabs4[k] <= cabs3[k];
        cneg4[k] <= cneg3[k];
      end
      if (en[2]) begin
        cabs5[k] <= cabs4[k];
        cneg5[k] <= cneg4[k];
      end
      if (en[3]) begin
        cabs6[k] <= cabs5[k];
        neg6[k]  <= cneg5[k] ^ det[m3i_pkg::DET_W-1];
      end
      if (en[4]) begin
        num[k] <= m3i_pkg::NUM_W'({cabs6[k], {m3i_pkg::NUM_SHIFT{1'b0}}})
                + m3i_pkg::NUM_W'(md);
        stat.neg[k] <= neg6[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sl <= m3i_pkg::SL_W'(pl[0]) + m3i_pkg::SL_W'(pl[1]) + m3i_pkg::SL_W'(pl[2]);
      sh <= m3i_pkg::SH_W'(ph[0]) + m3i_pkg::SH_W'(ph[1]) + m3i_pkg::SH_W'(ph[2]);
    end
    if (en[2]) begin
      det <= (m3i_pkg::DET_W'(sh) <<< m3i_pkg::COF_LO_W) + m3i_pkg::DET_W'(sl);
    end
    if (en[3]) begin
      md <= det[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-det) : m3i_pkg::DET_W'(det);
      dz <= (det == '0);
    end
    if (en[4]) begin
      den       <= {md, 1'b0};
      stat.sing <= dz || (md < m3i_pkg::DET_W'({thr, {m3i_pkg::THR_SHIFT{1'b0}}}));
    end
  end

endmodule
`default_nettype wire

/* rtl/core/m3i_div.sv */
// Nine-lane restoring divider, one quotient bit per stage, shared divisor
`default_nettype none
module m3i_div (
  input  logic                 clk,
  input  logic [m3i_pkg::QW:0] en,
  input  m3i_pkg::num_arr_t    num,
  input  m3i_pkg::num_t        den,
  input  logic [m3i_pkg::N_ENT-1:0] neg,
  output m3i_pkg::quo_arr_t    q_out,
  output m3i_pkg::div_stat_t   stat
);

  localparam int unsigned NE = m3i_pkg::N_ENT;
  localparam int unsigned QW = m3i_pkg::QW;
  localparam int unsigned RW = m3i_pkg::RW;

  logic [RW-1:0]          r   [0:QW-1][0:NE-1];
  logic [QW-1:0]          q   [1:QW][0:NE-1];
  logic [NE-1:0]          ovf [0:QW];
  logic [NE-1:0]          ng  [0:QW];
  logic [m3i_pkg::NUM_W-1:0] dd [0:QW-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dd[0]  <= den;
      ng[0]  <= neg;
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_in
    always_ff @(posedge clk) begin
      if (en[0]) begin
        r[0][k]   <= RW'(num[k]);
        ovf[0][k] <= RW'(num[k]) >= (RW'(den) << QW);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        ovf[j+1] <= ovf[j];
        ng[j+1]  <= ng[j];
      end
    end
    if (j < QW - 1) begin : g_dd
      always_ff @(posedge clk) begin
        if (en[j+1]) dd[j+1] <= dd[j];
      end
    end
    for (genvar k = 0; k < NE; k++) begin : g_lane
      logic [RW-1:0] t;
      logic [RW:0]   diff;
      logic          ge;
      assign t    = RW'(dd[j]) << (QW - 1 - j);
      assign diff = {1'b0, r[j][k]} - {1'b0, t};
      assign ge   = !diff[RW];
      if (j == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en[j+1]) q[j+1][k] <= QW'(ge);
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en[j+1]) q[j+1][k] <= {q[j][k][QW-2:0], ge};
        end
      end
      if (j < QW - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en[j+1]) r[j+1][k] <= ge ? diff[RW-1:0] : r[j][k];
        end
      end
      if (j == QW - 1) begin : g_out
        assign q_out[k] = q[QW][k];
      end
    end
  end

  assign stat.ovf = ovf[QW];
  assign stat.neg = ng[QW];

endmodule
`default_nettype wire

/* rtl/core/matrix3_inverse.sv */
// Top level of the 3x3 matrix inverse pipeline
//
// s_* carries one matrix per transaction, nine signed Q16.16 entries in
// s_tdata (row-major, row 0 column 0 lowest). m_* returns the inverse in the
// same layout; m_tuser is the singular flag, and with it set m_tdata holds the
// input matrix unchanged. cfg_wr_en/cfg_wr_data write the singular threshold.
// Throughput: one matrix per cycle while the receiver does not stall. The
// pipeline has 42 stages, of which 33 are the bit-per-stage divider (overflow
// check and 32 quotient bits).
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and input is taken while a result waits at the output.
// When the receiver stalls the pipeline fills and s_tready drops; nothing
// is lost or repeated. Reset clears all valid bits and sets the threshold to
// its default of 16.
`default_nettype none
module matrix3_inverse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [m3i_pkg::TDATA_W-1:0] s_tdata,   // in_r0c0 .. in_r2c2, 32 bits each
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [m3i_pkg::TDATA_W-1:0] m_tdata,   // inv_r0c0 .. inv_r2c2, 32 bits each
  output logic                        m_tuser,   // singular
  input  logic                        cfg_wr_en,
  input  logic [m3i_pkg::THR_W-1:0]   cfg_wr_data
);

  localparam int unsigned NS = m3i_pkg::NS;
  localparam int unsigned NE = m3i_pkg::N_ENT;
  localparam int unsigned EW = m3i_pkg::ENT_W;

  logic [NS-1:0]             v;
  logic [NS:0]               en;
  logic [m3i_pkg::THR_W-1:0] thr;
  m3i_pkg::mat_t             pt [0:NS-2];
  logic                      sg [m3i_pkg::SING_S+1:NS-2];
  m3i_pkg::cof_arr_t         cof;
  m3i_pkg::num_arr_t         num;
  m3i_pkg::num_t             den;
  m3i_pkg::det_stat_t        dstat;
  m3i_pkg::quo_arr_t         quo;
  m3i_pkg::div_stat_t        vstat;
  m3i_pkg::entry_t           res [0:NE-1];

  assign en[NS] = m_tready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      thr <= m3i_pkg::THR_W'(m3i_pkg::THR_RESET);
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (en[0]) v[0] <= s_tvalid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_in
    always_ff @(posedge clk) begin
      if (en[0]) pt[0][k] <= s_tdata[k*EW +: EW];
    end
  end

  for (genvar s = 1; s < NS - 1; s++) begin : g_pt
    always_ff @(posedge clk) begin
      if (en[s]) pt[s] <= pt[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[m3i_pkg::SING_S+1]) sg[m3i_pkg::SING_S+1] <= dstat.sing;
  end
  for (genvar s = m3i_pkg::SING_S + 2; s < NS - 1; s++) begin : g_sg
    always_ff @(posedge clk) begin
      if (en[s]) sg[s] <= sg[s-1];
    end
  end

  m3i_cof u_cof (
    .clk (clk),
    .en  (en[2:1]),
    .a   (pt[0]),
    .c   (cof)
  );

  m3i_det u_det (
    .clk  (clk),
    .en   (en[m3i_pkg::SING_S:3]),
    .a    (pt[2]),
    .c    (cof),
    .thr  (thr),
    .num  (num),
    .den  (den),
    .stat (dstat)
  );

  m3i_div u_div (
    .clk   (clk),
    .en    (en[m3i_pkg::DIV_S0 +: m3i_pkg::QW+1]),
    .num   (num),
    .den   (den),
    .neg   (dstat.neg),
    .q_out (quo),
    .stat  (vstat)
  );

  for (genvar k = 0; k < NE; k++) begin : g_sat
    always_comb begin
      if (!vstat.neg[k]) begin
        res[k] = (vstat.ovf[k] || quo[k][EW-1]) ? m3i_pkg::ENT_MAX : quo[k];
      end else if (vstat.ovf[k] || (quo[k][EW-1] && (quo[k][EW-2:0] != '0))) begin
        res[k] = m3i_pkg::ENT_MIN;
      end else begin
        res[k] = -quo[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en[NS-1]) begin
        m_tdata[k*EW +: EW] <= sg[NS-2] ? pt[NS-2][k] : res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) m_tuser <= sg[NS-2];
  end

endmodule
`default_nettype wire

/* rtl/core/m3i_check.sv */
// Port checker for the matrix inverse, bound to the top level
`default_nettype none
`include "matrix3_inverse_defines.svh"
module m3i_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [m3i_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic                        m_tuser
);

  `M3I_ASSERT_RST(a_rst_empty, clk, rst, !m_tvalid, "output valid after reset")
  `M3I_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output transaction changed")
  `M3I_ASSERT_IMP(a_full_only, clk, rst, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

endmodule

bind matrix3_inverse m3i_check u_check (.*);
`default_nettype wire
